[rtl/sbfm_pkg.sv]
// ----------------------------------------------------------------------------
// sbfm_pkg: shared types and constants of the batch fade mixer
// Register indexes of the configuration port and the mix bus width.
// ----------------------------------------------------------------------------
`default_nettype none

package sbfm_pkg;

  // mix bus width, fixed by the bus format
  localparam int MIX_WIDTH = 32;

  // configuration port index width
  localparam int CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_BATCH_TIME   = 3'd0,
    CFG_START_INDEX  = 3'd1,
    CFG_END_INDEX    = 3'd2,
    CFG_FADE_IN_LEN  = 3'd3,
    CFG_FADE_OUT_LEN = 3'd4,
    CFG_FADE_CURVE   = 3'd5,
    CFG_PLAY_REVERSE = 3'd6
  } cfg_index_t;

endpackage

`default_nettype wire

[rtl/sbfm_front.sv]
// ----------------------------------------------------------------------------
// sbfm_front: position, batch length, region and ramp operands
// Three register stages: position and length, region bounds and address,
// ramp numerator/denominator and unity flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfm_front import sbfm_pkg::*; #(
  parameter int TW  = 48,
  parameter int AW  = 24,
  parameter int SW  = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire logic [TW-1:0]        sample_time,
  input  wire logic signed [SW-1:0] source_sample,
  input  wire logic signed [MIX_WIDTH-1:0] mix_in,
  input  wire logic                 block_last,
  input  wire logic [TW-1:0]        batch_time,
  input  wire logic [AW-1:0]        start_index,
  input  wire logic [AW-1:0]        end_index,
  input  wire logic [AW-1:0]        fade_in_length,
  input  wire logic [AW-1:0]        fade_out_length,
  input  wire logic                 play_reverse,
  output logic                      out_valid,
  output logic [AW-1:0]             num,
  output logic [AW-1:0]             den,
  output logic                      unity,
  output logic                      act,
  output logic [AW-1:0]             addr,
  output logic signed [SW-1:0]      src,
  output logic signed [MIX_WIDTH-1:0] mix,
  output logic                      last
);

  // stage A registers
  logic                 vld_a;
  logic [TW-1:0]        t_a;
  logic [AW-1:0]        len_a;
  logic signed [SW-1:0] src_a;
  logic signed [MIX_WIDTH-1:0] mix_a;
  logic                 last_a;

  // stage B registers
  logic                 vld_b;
  logic                 act_b;
  logic [AW-1:0]        tl_b;
  logic [AW-1:0]        len_b;
  logic [AW-1:0]        fi_b;
  logic [AW-1:0]        be_b;
  logic [AW-1:0]        addr_b;
  logic signed [SW-1:0] src_b;
  logic signed [MIX_WIDTH-1:0] mix_b;
  logic                 last_b;

  logic [AW-1:0] len_calc;
  logic [AW-1:0] tl_a;
  logic          fin_b;
  logic [AW-1:0] tail_b;

  // batch length, zero when indices are inverted
  always_comb begin
    if (play_reverse) begin
      len_calc = (start_index > end_index) ? start_index - end_index : '0;
    end else begin
      len_calc = (end_index > start_index) ? end_index - start_index : '0;
    end
  end

  assign tl_a   = t_a[AW-1:0];
  assign fin_b  = tl_b < fi_b;
  assign tail_b = len_b - tl_b;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_a     <= in_valid;
      vld_b     <= vld_a;
      out_valid <= vld_b;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage A: position and length
      t_a    <= sample_time - batch_time;
      len_a  <= len_calc;
      src_a  <= source_sample;
      mix_a  <= mix_in;
      last_a <= block_last;
      // stage B: activity, region bounds, source address
      act_b  <= t_a < TW'(len_a);
      tl_b   <= tl_a;
      len_b  <= len_a;
      fi_b   <= (fade_in_length < len_a) ? fade_in_length : len_a;
      be_b   <= (fade_out_length > len_a) ? '0 : len_a - fade_out_length;
      addr_b <= play_reverse ? start_index - AW'(1) - tl_a : start_index + tl_a;
      src_b  <= src_a;
      mix_b  <= mix_a;
      last_b <= last_a;
      // stage C: ramp operands
      act    <= act_b;
      num    <= fin_b ? tl_b : tail_b;
      den    <= fin_b ? fi_b : fade_out_length;
      unity  <= !fin_b && ((tl_b < be_b) || (tail_b >= fade_out_length));
      addr   <= act_b ? addr_b : '0;
      src    <= src_b;
      mix    <= mix_b;
      last   <= last_b;
    end
  end

endmodule

`default_nettype wire

[rtl/sbfm_div.sv]
// ----------------------------------------------------------------------------
// sbfm_div: pipelined restoring divider
// One quotient bit per stage: q = floor(num * 2^QB / den), num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfm_div #(
  parameter int AW  = 24,
  parameter int QB  = 32,
  parameter int SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_valid,
  input  wire logic [AW-1:0]  num,
  input  wire logic [AW-1:0]  den,
  input  wire logic [SBW-1:0] sb_in,
  output logic                out_valid,
  output logic [QB-1:0]       q,
  output logic [SBW-1:0]      sb_out
);

  logic [AW-1:0]  rem_r [QB];
  logic [AW-1:0]  den_r [QB];
  logic [QB-1:0]  q_r   [QB];
  logic [SBW-1:0] sb_r  [QB];
  logic           vld   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [AW-1:0]  rem_p;
    logic [AW-1:0]  den_p;
    logic [QB-1:0]  q_p;
    logic [SBW-1:0] sb_p;
    logic           vld_p;
    logic [AW:0]    r2;
    logic [AW:0]    diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_p = num;
      assign den_p = den;
      assign q_p   = '0;
      assign sb_p  = sb_in;
      assign vld_p = in_valid;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign den_p = den_r[i-1];
      assign q_p   = q_r[i-1];
      assign sb_p  = sb_r[i-1];
      assign vld_p = vld[i-1];
    end

    // one restoring step
    assign r2   = {rem_p, 1'b0};
    assign ge   = r2 >= {1'b0, den_p};
    assign diff = r2 - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= ge ? diff[AW-1:0] : r2[AW-1:0];
        den_r[i] <= den_p;
        q_r[i]   <= {q_p[QB-2:0], ge};
        sb_r[i]  <= sb_p;
      end
    end
  end

  assign out_valid = vld[QB-1];
  assign q         = q_r[QB-1];
  assign sb_out    = sb_r[QB-1];

endmodule

`default_nettype wire

[rtl/sbfm_sqrt.sv]
// ----------------------------------------------------------------------------
// sbfm_sqrt: pipelined integer square root
// Two radicand bits per stage, floor(sqrt(x)) of a 2G-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfm_sqrt #(
  parameter int G   = 16,
  parameter int SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_valid,
  input  wire logic [2*G-1:0] x,
  input  wire logic [SBW-1:0] sb_in,
  output logic                out_valid,
  output logic [G-1:0]        root,
  output logic [SBW-1:0]      sb_out
);

  logic [G+1:0]   rem_r  [G];
  logic [G-1:0]   root_r [G];
  logic [2*G-1:0] x_r    [G];
  logic [SBW-1:0] sb_r   [G];
  logic           vld    [G];

  for (genvar i = 0; i < G; i++) begin : g_stage
    logic [G+1:0]   rem_p;
    logic [G-1:0]   root_p;
    logic [2*G-1:0] x_p;
    logic [SBW-1:0] sb_p;
    logic           vld_p;
    logic [G+3:0]   cur;
    logic [G+3:0]   trial;
    logic [G+3:0]   diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x;
      assign sb_p   = sb_in;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign x_p    = x_r[i-1];
      assign sb_p   = sb_r[i-1];
      assign vld_p  = vld[i-1];
    end

    // bring down the next bit pair, try root*4+1
    assign cur   = {rem_p, x_p[2*G-1-2*i -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= ge ? diff[G+1:0] : cur[G+1:0];
        root_r[i] <= {root_p[G-2:0], ge};
        x_r[i]    <= x_p;
        sb_r[i]   <= sb_p;
      end
    end
  end

  assign out_valid = vld[G-1];
  assign root      = root_r[G-1];
  assign sb_out    = sb_r[G-1];

endmodule

`default_nettype wire

[rtl/sbfm_mac.sv]
// ----------------------------------------------------------------------------
// sbfm_mac: gain multiply, rounding and saturating mix add
// Stage 1 registers the product, stage 2 the saturated bus sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfm_mac import sbfm_pkg::*; #(
  parameter int SW  = 24,
  parameter int G   = 16,
  parameter int SBW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire logic signed [SW-1:0] src,
  input  wire logic signed [MIX_WIDTH-1:0] mix,
  input  wire logic [G:0]           gain_in,
  input  wire logic [SBW-1:0]       sb_in,
  output logic                      out_valid,
  output logic signed [MIX_WIDTH-1:0] sum_out,
  output logic [G:0]                gain_out,
  output logic [SBW-1:0]            sb_out
);

  localparam int PW   = SW + G + 2;
  localparam int WW   = PW - G;
  localparam int SUMW = ((WW > MIX_WIDTH) ? WW : MIX_WIDTH) + 1;

  logic                        vld_p;
  logic signed [PW-1:0]        prod;
  logic signed [MIX_WIDTH-1:0] mix_p;
  logic [G:0]                  gain_p;
  logic [SBW-1:0]              sb_p;

  logic signed [PW-1:0]   rnd;
  logic signed [WW-1:0]   wtd;
  logic signed [SUMW-1:0] sum;
  logic [SUMW-MIX_WIDTH:0] top_bits;
  logic signed [MIX_WIDTH-1:0] sat;

  // round half up, then add to the bus
  assign rnd      = prod + PW'(1 << (G - 1));
  assign wtd      = WW'(rnd >>> G);
  assign sum      = SUMW'(mix_p) + SUMW'(wtd);
  assign top_bits = sum[SUMW-1:MIX_WIDTH-1];

  // saturate when the upper bits disagree with the sign
  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      sat = sum[MIX_WIDTH-1:0];
    end else if (sum[SUMW-1]) begin
      sat = {1'b1, {(MIX_WIDTH-1){1'b0}}};
    end else begin
      sat = {1'b0, {(MIX_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_p     <= in_valid;
      out_valid <= vld_p;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod     <= PW'(src) * $signed({1'b0, gain_in});
      mix_p    <= mix;
      gain_p   <= gain_in;
      sb_p     <= sb_in;
      sum_out  <= sat;
      gain_out <= gain_p;
      sb_out   <= sb_p;
    end
  end

endmodule

`default_nettype wire

[rtl/sample_batch_fade_mixer_core.sv]
// ----------------------------------------------------------------------------
// sample_batch_fade_mixer_core: faded batch sample added into a mix bus
// Envelope gain (linear or square-root ramp) applied per sample, saturated.
// ----------------------------------------------------------------------------
//  channel | signals                                           | direction
//  input   | in_valid/in_ready, sample_time, source_sample,    | request in
//          | mix_in, block_last                                |
//  output  | out_valid/out_ready, mix_out, active,             | request out
//          | source_address, gain, block_last_out              |
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data          | request in
//
// One request per cycle unless an output stall holds it; the gain passes the
// one-bit-per-stage divider (2*GAIN_FRAC_BITS stages) and the square-root
// pipeline (GAIN_FRAC_BITS stages). All stages advance together; an output
// stall freezes the whole pipeline, in_ready follows the output side.
// Reset clears the valid bits and the configuration registers; in_ready and
// cfg_ready are low during reset, cfg_ready is high otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_batch_fade_mixer_core import sbfm_pkg::*; #(
  parameter int ADDR_WIDTH     = 24,
  parameter int SAMPLE_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 16,
  parameter int TIME_WIDTH     = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [TIME_WIDTH-1:0]          sample_time,
  input  wire logic signed [SAMPLE_WIDTH-1:0] source_sample,
  input  wire logic signed [MIX_WIDTH-1:0]    mix_in,
  input  wire logic                           block_last,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [MIX_WIDTH-1:0]         mix_out,
  output logic                                active,
  output logic [ADDR_WIDTH-1:0]               source_address,
  output logic [GAIN_FRAC_BITS:0]             gain,
  output logic                                block_last_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0]       cfg_index,
  input  wire logic [TIME_WIDTH-1:0]          cfg_data
);

  localparam int AW  = ADDR_WIDTH;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int G   = GAIN_FRAC_BITS;
  // sideband: src, mix, last, act, unity, addr
  localparam int DSB = SW + MIX_WIDTH + 3 + AW;
  // plus linear gain
  localparam int QSB = DSB + G;
  // mac sideband: act, last, addr
  localparam int MSB = AW + 2;

  // configuration registers
  logic [TIME_WIDTH-1:0] batch_time;
  logic [AW-1:0]         start_index;
  logic [AW-1:0]         end_index;
  logic [AW-1:0]         fade_in_length;
  logic [AW-1:0]         fade_out_length;
  logic                  fade_curve;
  logic                  play_reverse;

  logic adv;

  logic                        f_valid;
  logic [AW-1:0]               f_num;
  logic [AW-1:0]               f_den;
  logic                        f_unity;
  logic                        f_act;
  logic [AW-1:0]               f_addr;
  logic signed [SW-1:0]        f_src;
  logic signed [MIX_WIDTH-1:0] f_mix;
  logic                        f_last;

  logic           d_valid;
  logic [2*G-1:0] d_q;
  logic [DSB-1:0] d_sb;

  logic           s_valid;
  logic [G-1:0]   s_root;
  logic [QSB-1:0] s_sb;

  logic [G-1:0]                s_lin;
  logic signed [SW-1:0]        s_src;
  logic signed [MIX_WIDTH-1:0] s_mix;
  logic                        s_last;
  logic                        s_act;
  logic                        s_unity;
  logic [AW-1:0]               s_addr;
  logic [G:0]                  s_gain;

  logic [MSB-1:0] m_sb;

  // whole pipeline holds while a result waits
  assign adv       = !(out_valid && !out_ready);
  assign in_ready  = adv && !rst;
  assign cfg_ready = !rst;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_time      <= '0;
      start_index     <= '0;
      end_index       <= '0;
      fade_in_length  <= '0;
      fade_out_length <= '0;
      fade_curve      <= 1'b0;
      play_reverse    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_BATCH_TIME:   batch_time      <= cfg_data;
        CFG_START_INDEX:  start_index     <= cfg_data[AW-1:0];
        CFG_END_INDEX:    end_index       <= cfg_data[AW-1:0];
        CFG_FADE_IN_LEN:  fade_in_length  <= cfg_data[AW-1:0];
        CFG_FADE_OUT_LEN: fade_out_length <= cfg_data[AW-1:0];
        CFG_FADE_CURVE:   fade_curve      <= cfg_data[0];
        CFG_PLAY_REVERSE: play_reverse    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sbfm_front #(.TW(TIME_WIDTH), .AW(AW), .SW(SW)) u_front (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (in_valid),
    .sample_time     (sample_time),
    .source_sample   (source_sample),
    .mix_in          (mix_in),
    .block_last      (block_last),
    .batch_time      (batch_time),
    .start_index     (start_index),
    .end_index       (end_index),
    .fade_in_length  (fade_in_length),
    .fade_out_length (fade_out_length),
    .play_reverse    (play_reverse),
    .out_valid       (f_valid),
    .num             (f_num),
    .den             (f_den),
    .unity           (f_unity),
    .act             (f_act),
    .addr            (f_addr),
    .src             (f_src),
    .mix             (f_mix),
    .last            (f_last)
  );

  sbfm_div #(.AW(AW), .QB(2*G), .SBW(DSB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .sb_in     ({f_src, f_mix, f_last, f_act, f_unity, f_addr}),
    .out_valid (d_valid),
    .q         (d_q),
    .sb_out    (d_sb)
  );

  sbfm_sqrt #(.G(G), .SBW(QSB)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .x         (d_q),
    .sb_in     ({d_q[2*G-1:G], d_sb}),
    .out_valid (s_valid),
    .root      (s_root),
    .sb_out    (s_sb)
  );

  assign {s_lin, s_src, s_mix, s_last, s_act, s_unity, s_addr} = s_sb;

  // envelope gain select
  always_comb begin
    if (!s_act) begin
      s_gain = '0;
    end else if (s_unity) begin
      s_gain = {1'b1, {G{1'b0}}};
    end else if (fade_curve) begin
      s_gain = {1'b0, s_root};
    end else begin
      s_gain = {1'b0, s_lin};
    end
  end

  sbfm_mac #(.SW(SW), .G(G), .SBW(MSB)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_valid),
    .src       (s_src),
    .mix       (s_mix),
    .gain_in   (s_gain),
    .sb_in     ({s_act, s_last, s_addr}),
    .out_valid (out_valid),
    .sum_out   (mix_out),
    .gain_out  (gain),
    .sb_out    (m_sb)
  );

  assign {active, block_last_out, source_address} = m_sb;

endmodule

`default_nettype wire
